>>> design/lbps_pkg.sv
// ----------------------------------------------------------------------------
// lbps_pkg
// Shared types and constants for the LED and button panel scanner: item
// kinds, LED drive modes, and the millisecond timing of the blink patterns.
// ----------------------------------------------------------------------------
`default_nettype none

package lbps_pkg;

   // Panel geometry
   localparam int NUM_CH     = 16;
   localparam int CH_IDX_W   = 4;
   localparam int LED_NUM_W  = 5;
   localparam int DEV_IDX_W  = 6;

   // Millisecond timer: counts 0..CYCLE_LAST
   localparam int TIMER_W    = 9;
   localparam logic [TIMER_W-1:0] CYCLE_LAST  = TIMER_W'(500 - 1);
   localparam logic [TIMER_W-1:0] SLOW_ON_MS  = TIMER_W'(250);

   // Fast blink: toggle every FAST_HALF_LAST+1 ticks, starting on
   localparam int FAST_CNT_W = 6;
   localparam logic [FAST_CNT_W-1:0] FAST_HALF_LAST = FAST_CNT_W'(50 - 1);

   // Item kinds
   typedef enum logic {
      KIND_TICK    = 1'b0,
      KIND_SET_LED = 1'b1
   } item_kind_type;

   // LED drive modes
   typedef enum logic [1:0] {
      MODE_OFF  = 2'd0,
      MODE_ON   = 2'd1,
      MODE_SLOW = 2'd2,
      MODE_FAST = 2'd3
   } led_mode_type;

endpackage : lbps_pkg

`default_nettype wire

>>> design/led_button_panel_scanner.sv
// ----------------------------------------------------------------------------
// led_button_panel_scanner
// Scans a 16-channel LED and button panel. A tick shifts one sample per
// channel into its debounce history, reports pressed channels and a device
// index, and drives LED levels from per-channel modes. A set-LED transaction
// stores one channel's mode and returns nothing.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Payload
//  req_     in         req_valid/req_stall   kind, sampled_bits, led_number,
//                                            led_mode
//  rsp_     out        rsp_valid/rsp_stall   drive_bits, pressed_bits,
//                                            device_index
//
//  One transaction per cycle while req_stall is low; a tick's result is
//  registered at acceptance. All 16 channels are updated in parallel by the
//  logic between the state registers and the output register.
//  reset (synchronous) clears histories, LED modes, the timer and rsp_valid.
//  req_stall is high only while a result is held and rsp_stall is high; a new
//  transaction is taken in the same cycle the held result leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module led_button_panel_scanner #(
   parameter int HISTORY_DEPTH = 8
) (
   input  wire logic                             clock,
   input  wire logic                             reset,

   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire logic                             req_kind,
   input  wire logic [lbps_pkg::NUM_CH-1:0]      req_sampled_bits,
   input  wire logic [lbps_pkg::LED_NUM_W-1:0]   req_led_number,
   input  wire logic [1:0]                       req_led_mode,

   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output logic [lbps_pkg::NUM_CH-1:0]           rsp_drive_bits,
   output logic [lbps_pkg::NUM_CH-1:0]           rsp_pressed_bits,
   output logic [lbps_pkg::DEV_IDX_W-1:0]        rsp_device_index
);

   import lbps_pkg::*;

   // State
   logic [HISTORY_DEPTH-1:0] hist_ff [NUM_CH];
   logic [HISTORY_DEPTH-1:0] hist_in [NUM_CH];
   led_mode_type             mode_ff [NUM_CH];
   logic [TIMER_W-1:0]       timer_ff, timer_in;
   logic [FAST_CNT_W-1:0]    fast_cnt_ff, fast_cnt_in;
   logic                     fast_phase_ff, fast_phase_in;

   // Result register
   logic                     rsp_valid_ff;
   logic [NUM_CH-1:0]        rsp_drive_ff, rsp_drive_in;
   logic [NUM_CH-1:0]        rsp_pressed_ff, rsp_pressed_in;
   logic [DEV_IDX_W-1:0]     rsp_index_ff, rsp_index_in;

   logic                     req_accept;
   logic                     is_tick;
   logic                     is_set;
   logic                     num_ok;
   logic [CH_IDX_W-1:0]      set_idx;
   logic                     timer_wrap;
   logic                     fast_wrap;

   // Handshake: stall only while a held result cannot leave
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;
   assign is_tick    = req_accept & (item_kind_type'(req_kind) == KIND_TICK);
   assign is_set     = req_accept & (item_kind_type'(req_kind) == KIND_SET_LED);

   // LED n maps to channel position 16-n
   assign num_ok  = (req_led_number != '0) && (req_led_number <= LED_NUM_W'(NUM_CH));
   assign set_idx = CH_IDX_W'(LED_NUM_W'(NUM_CH) - req_led_number);

   // Shift samples into histories, detect full-ones history, compute drive
   always_comb begin
      for (int k = 0; k < NUM_CH; k++) begin
         hist_in[k]        = {hist_ff[k][HISTORY_DEPTH-2:0], req_sampled_bits[k]};
         rsp_pressed_in[k] = &hist_in[k];
         case (mode_ff[k])
            MODE_OFF:  rsp_drive_in[k] = 1'b0;
            MODE_ON:   rsp_drive_in[k] = 1'b1;
            MODE_SLOW: rsp_drive_in[k] = (timer_ff < SLOW_ON_MS);
            MODE_FAST: rsp_drive_in[k] = ~fast_phase_ff;
            default:   rsp_drive_in[k] = 1'b0;
         endcase
      end
      rsp_index_in = {rsp_pressed_in[9], rsp_pressed_in[8], rsp_pressed_in[15],
                      rsp_pressed_in[14], rsp_pressed_in[13], rsp_pressed_in[12]};
   end

   // Advance the millisecond timer and the fast blink phase
   assign timer_wrap = (timer_ff >= CYCLE_LAST);
   assign fast_wrap  = (fast_cnt_ff >= FAST_HALF_LAST);

   always_comb begin
      if (timer_wrap) begin
         timer_in      = '0;
         fast_cnt_in   = '0;
         fast_phase_in = 1'b0;
      end else if (fast_wrap) begin
         timer_in      = timer_ff + TIMER_W'(1);
         fast_cnt_in   = '0;
         fast_phase_in = ~fast_phase_ff;
      end else begin
         timer_in      = timer_ff + TIMER_W'(1);
         fast_cnt_in   = fast_cnt_ff + FAST_CNT_W'(1);
         fast_phase_in = fast_phase_ff;
      end
   end

   // Update panel state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NUM_CH; k++) begin
            hist_ff[k] <= '0;
            mode_ff[k] <= MODE_OFF;
         end
         timer_ff      <= '0;
         fast_cnt_ff   <= '0;
         fast_phase_ff <= 1'b0;
      end else begin
         if (is_tick) begin
            for (int k = 0; k < NUM_CH; k++) begin
               hist_ff[k] <= hist_in[k];
            end
            timer_ff      <= timer_in;
            fast_cnt_ff   <= fast_cnt_in;
            fast_phase_ff <= fast_phase_in;
         end
         if (is_set && num_ok) begin
            mode_ff[set_idx] <= led_mode_type'(req_led_mode);
         end
      end
   end

   // Load the result register on a tick, drop valid when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (is_tick) begin
         rsp_valid_ff <= 1'b1;
      end else if (~rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (is_tick) begin
         rsp_drive_ff   <= rsp_drive_in;
         rsp_pressed_ff <= rsp_pressed_in;
         rsp_index_ff   <= rsp_index_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_drive_bits   = rsp_drive_ff;
   assign rsp_pressed_bits = rsp_pressed_ff;
   assign rsp_device_index = rsp_index_ff;

   // Checks
   a_timer_range: assert property (@(posedge clock) disable iff (reset)
      timer_ff <= CYCLE_LAST)
      else $error("ms timer out of range");

   a_fast_aligned: assert property (@(posedge clock) disable iff (reset)
      (timer_ff == '0) |-> (fast_cnt_ff == '0 && !fast_phase_ff))
      else $error("fast blink phase not aligned to timer wrap");

   a_tick_result: assert property (@(posedge clock) disable iff (reset)
      is_tick |=> rsp_valid_ff)
      else $error("tick produced no result");

   a_set_no_result: assert property (@(posedge clock) disable iff (reset)
      (is_set && !(rsp_valid_ff && rsp_stall)) |=> !rsp_valid_ff)
      else $error("set-LED transaction produced a result");

   a_index_map: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_index_ff[3:0] == rsp_pressed_ff[15:12] &&
                        rsp_index_ff[5:4] == rsp_pressed_ff[9:8]))
      else $error("device index does not match pressed channels");

endmodule : led_button_panel_scanner

`default_nettype wire
